// ===== rtl/rscq_pkg.sv =====
// Package for the register shadow change queue: payload structs, opcodes,
// controller/datapath command and status structs, and fixed constants.
// Depends on nothing; the top level, datapath, controller and testbench import it.
`default_nettype none

package rscq_pkg;

   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int REG_COUNT_DEF   = 64;

   localparam int REG_ADDR_W = 6;
   localparam int VALUE_W    = 8;

   localparam logic [REG_ADDR_W-1:0] KEY_REG_FIRST = 6'h20;
   localparam logic [REG_ADDR_W-1:0] KEY_REG_LAST  = 6'h28;
   localparam logic [VALUE_W-1:0]    KEY_OFF_MASK  = 8'h0f;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index as decoded from csr_paddr[2].
   localparam logic CSR_IDX_DEVICE_PRESENT = 1'b0;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_FLUSH = 2'd1,
      OP_STOP  = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type              opcode;
      logic [REG_ADDR_W-1:0]   reg_addr;
      logic [VALUE_W-1:0]      write_value;
   } req_type;

   typedef struct packed {
      logic [REG_ADDR_W-1:0]   out_reg;
      logic [VALUE_W-1:0]      out_value;
      logic                    last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;      // latch the accepted request
      logic sh_rd_req;    // read the shadow at the request address
      logic sh_rd_key;    // read the shadow at the next key-off register
      logic put_commit;   // write shadow, append to queue if room
      logic q_rd;         // read the queue at the run index
      logic idx_inc;
      logic idx_clr;
      logic out_load;     // load the output register from the read data
      logic out_src_key;  // output comes from the shadow (stop) not the queue
      logic flush_done;   // empty the queue
      logic clear_all;    // invalidate shadow and empty the queue
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      opcode_type opcode;
      logic       addr_ok;
      logic       present;
      logic       count_zero;
      logic       put_same;
      logic       out_free;
      logic       rd_last;
   } ctl_status_type;

endpackage

`default_nettype wire

// ===== rtl/register_shadow_change_queue.sv =====
// Top level of the register shadow change queue: joins the controller and
// the datapath. Depends on rscq_pkg, rscq_controller and rscq_datapath.
//
//   Port group  Dir  Handshake              Contents
//   req_*       in   req_valid / req_stall  req_type: opcode, reg_addr, write_value
//   rsp_*       out  rsp_valid / rsp_stall  rsp_type: out_reg, out_value, last
//   csr_*       in   APB, pready always 1   device_present at byte address 0
//
// A put first reads the shadow, then compares and writes.
// A clear, a put outside the shadow, or a flush or stop emitting nothing stays idle.
// A flush of N entries or a stop (nine writes) issues one memory read per cycle
// while rsp is not stalled, so results follow one per cycle from the registered read.
// Stalls on rsp hold the run; the next request is taken once the run ends.
// Reset is synchronous; no clearing pass is needed after it.
`default_nettype none

module register_shadow_change_queue
   import rscq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int REG_COUNT   = REG_COUNT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   dp_cmd_type     cmd;
   ctl_status_type status;

   rscq_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rscq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .REG_COUNT   (REG_COUNT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

`default_nettype wire

// ===== rtl/rscq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Used for the shadow store and the change queue; no dependencies.
`default_nettype none

module rscq_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/rscq_datapath.sv =====
// Datapath: shadow store with valid bits, change queue with fill count,
// run index, output register and the device_present register.
// Depends on rscq_pkg and rscq_ram.
`default_nettype none

module rscq_datapath
   import rscq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int REG_COUNT   = REG_COUNT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_type               req_data,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   input  wire dp_cmd_type            cmd,
   output ctl_status_type             status
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int Q_AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int IDX_W = (CNT_W > 4) ? CNT_W : 4;
   localparam int SH_AW = $clog2(REG_COUNT);
   localparam int Q_W   = REG_ADDR_W + VALUE_W;
   localparam logic [IDX_W-1:0] KEY_SPAN = IDX_W'(KEY_REG_LAST - KEY_REG_FIRST);

   logic                  present_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [REG_COUNT-1:0]  sh_vld_ff;
   logic [REG_ADDR_W-1:0] cap_addr_ff;
   logic [VALUE_W-1:0]    cap_value_ff;
   logic                  rd_vld_ff;
   logic                  rd_last_ff;
   logic [REG_ADDR_W-1:0] rd_reg_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic                  csr_wr;
   logic                  room;
   logic                  out_free;
   logic [SH_AW-1:0]      key_addr;
   logic [SH_AW-1:0]      sh_raddr;
   logic [SH_AW-1:0]      sh_waddr;
   logic                  sh_re;
   logic [VALUE_W-1:0]    sh_rdata;
   logic [VALUE_W-1:0]    sh_value;
   logic                  q_we;
   logic [Q_W-1:0]        q_rdata;
   logic [REG_ADDR_W-1:0] key_reg;
   logic                  flush_last;
   rsp_type               load_rsp;

   // Configuration register.
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_DEVICE_PRESENT)
                       ? CSR_DATA_W'(present_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b1;
      end else if (csr_wr && csr_paddr[2] == CSR_IDX_DEVICE_PRESENT) begin
         present_ff <= csr_pwdata[0];
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cap_addr_ff  <= req_data.reg_addr;
         cap_value_ff <= req_data.write_value;
      end
   end

   // Shadow store. Entries never written since reset or clear read as zero.
   assign key_reg  = KEY_REG_FIRST + REG_ADDR_W'(idx_ff[3:0]);
   assign key_addr = SH_AW'(key_reg);
   assign sh_raddr = cmd.sh_rd_req ? SH_AW'(req_data.reg_addr) : key_addr;
   assign sh_waddr = SH_AW'(cap_addr_ff);
   assign sh_re    = cmd.sh_rd_req || cmd.sh_rd_key;

   rscq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (REG_COUNT)
   ) u_shadow (
      .clock (clock),
      .we    (cmd.put_commit),
      .waddr (sh_waddr),
      .wdata (cap_value_ff),
      .re    (sh_re),
      .raddr (sh_raddr),
      .rdata (sh_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         sh_vld_ff <= '0;
      end else if (cmd.put_commit) begin
         sh_vld_ff[sh_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (sh_re) begin
         rd_vld_ff <= sh_vld_ff[sh_raddr];
      end
   end

   assign sh_value = rd_vld_ff ? sh_rdata : '0;

   // Change queue.
   assign room = count_ff < CNT_W'(QUEUE_DEPTH);
   assign q_we = cmd.put_commit && room;

   rscq_ram #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .we    (q_we),
      .waddr (count_ff[Q_AW-1:0]),
      .wdata ({cap_addr_ff, cap_value_ff}),
      .re    (cmd.q_rd),
      .raddr (idx_ff[Q_AW-1:0]),
      .rdata (q_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all || cmd.flush_done) begin
         count_ff <= '0;
      end else if (q_we) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // Run index, shared by flush (queue slot) and stop (key-off register).
   always_ff @(posedge clock) begin
      if (reset || cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   assign flush_last = ({1'b0, idx_ff} + (IDX_W + 1)'(1)) == (IDX_W + 1)'(count_ff);

   // The last flag and the register address travel alongside the memory read.
   always_ff @(posedge clock) begin
      if (cmd.q_rd) begin
         rd_last_ff <= flush_last;
      end else if (cmd.sh_rd_key) begin
         rd_last_ff <= (idx_ff == KEY_SPAN);
         rd_reg_ff  <= key_reg;
      end
   end

   // Output register.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (cmd.out_src_key) begin
         load_rsp.out_reg   = rd_reg_ff;
         load_rsp.out_value = sh_value & KEY_OFF_MASK;
      end else begin
         load_rsp.out_reg   = q_rdata[Q_W-1:VALUE_W];
         load_rsp.out_value = q_rdata[VALUE_W-1:0];
      end
      load_rsp.last = rd_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff <= load_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status back to the controller.
   assign status.opcode     = req_data.opcode;
   assign status.addr_ok    = (SH_AW + 1)'(req_data.reg_addr) < (SH_AW + 1)'(REG_COUNT);
   assign status.present    = present_ff;
   assign status.count_zero = (count_ff == '0);
   assign status.put_same   = (sh_value == cap_value_ff);
   assign status.out_free   = out_free;
   assign status.rd_last    = rd_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count above depth");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("output register overwritten while stalled");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.flush_done |=> (count_ff == '0))
      else $error("queue not empty after flush");

   a_queue_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.q_rd |-> ((IDX_W + 1)'(idx_ff) < (IDX_W + 1)'(count_ff)))
      else $error("queue read beyond fill count");

endmodule

`default_nettype wire

// ===== rtl/rscq_controller.sv =====
// Controller state machine: decodes accepted requests and sequences
// shadow compares and flush/stop runs. Depends on rscq_pkg.
`default_nettype none

module rscq_controller
   import rscq_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire ctl_status_type status,
   output dp_cmd_type          cmd
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_PUT   = 4'b0010,
      S_FLUSH = 4'b0100,
      S_STOP  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (status.opcode)
                  OP_PUT: begin
                     if (status.addr_ok) begin
                        cmd.sh_rd_req = 1'b1;
                        state_in      = S_PUT;
                     end
                  end
                  OP_FLUSH: begin
                     if (status.present && !status.count_zero) begin
                        cmd.q_rd    = 1'b1;
                        cmd.idx_inc = 1'b1;
                        state_in    = S_FLUSH;
                     end
                  end
                  OP_STOP: begin
                     if (status.present) begin
                        cmd.sh_rd_key = 1'b1;
                        cmd.idx_inc   = 1'b1;
                        state_in      = S_STOP;
                     end
                  end
                  OP_CLEAR: begin
                     cmd.clear_all = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PUT: begin
            cmd.put_commit = !status.put_same;
            state_in       = S_IDLE;
         end
         S_FLUSH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.rd_last) begin
                  cmd.idx_clr    = 1'b1;
                  cmd.flush_done = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  cmd.q_rd    = 1'b1;
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         S_STOP: begin
            cmd.out_src_key = 1'b1;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.rd_last) begin
                  cmd.idx_clr = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  cmd.sh_rd_key = 1'b1;
                  cmd.idx_inc   = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for register_shadow_change_queue: a directed table, then random
// phases, checked against a mirror of the shadow store and the change queue.
// Depends on rscq_pkg and the register_shadow_change_queue RTL.
`timescale 1ns / 100ps

module testbench
   import rscq_pkg::*;
();

   localparam int CLK_PERIOD   = 2;
   localparam int ITEM_TARGET  = 270;
   localparam int SETTLE_TICKS = 8;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int LIMIT_NS     = 2_000_000;
   localparam int MAX_REPORTS  = 10;

   localparam logic [CSR_ADDR_W-1:0] PRESENT_ADDR = {CSR_IDX_DEVICE_PRESENT, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR   = {~CSR_IDX_DEVICE_PRESENT, 2'b00};

   typedef enum {CHECK_MODEL, CHECK_SILENT, CHECK_SINGLE} check_kind_type;

   typedef struct {
      req_type        item;
      check_kind_type kind;
      rsp_type        want;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Mirror of the block's state.
   logic [VALUE_W-1:0]    shadow_mirror [REG_COUNT_DEF];
   logic [REG_ADDR_W-1:0] pending_addr  [QUEUE_DEPTH_DEF];
   logic [VALUE_W-1:0]    pending_value [QUEUE_DEPTH_DEF];
   int unsigned           pending_count;
   logic                  dev_present;

   rsp_type     new_writes[$];
   rsp_type     expected_writes[$];
   bit          steady;
   int unsigned errors;
   int unsigned items_sent;
   int unsigned ops_applied;
   int unsigned writes_checked;
   int unsigned puts_dropped;

   // Directed stimulus. Expected results are typed in where they are obvious.
   dir_row_type dir_table [22] = '{
      '{'{OP_STOP,  6'h00, 8'h00}, CHECK_MODEL,  '0},  // key-off with an all-zero shadow
      '{'{OP_FLUSH, 6'h3f, 8'hff}, CHECK_SILENT, '0},  // flush of an empty queue
      '{'{OP_PUT,   6'h00, 8'h00}, CHECK_SILENT, '0},  // same as the shadow, ignored
      '{'{OP_PUT,   6'h3f, 8'hff}, CHECK_SILENT, '0},
      '{'{OP_FLUSH, 6'h00, 8'h00}, CHECK_SINGLE, '{6'h3f, 8'hff, 1'b1}},
      '{'{OP_PUT,   6'h20, 8'hff}, CHECK_SILENT, '0},
      '{'{OP_PUT,   6'h28, 8'ha5}, CHECK_SILENT, '0},
      '{'{OP_PUT,   6'h24, 8'h3c}, CHECK_SILENT, '0},
      '{'{OP_PUT,   6'h1f, 8'h77}, CHECK_SILENT, '0},
      '{'{OP_PUT,   6'h29, 8'h81}, CHECK_SILENT, '0},
      '{'{OP_PUT,   6'h20, 8'hff}, CHECK_SILENT, '0},  // repeated value, ignored
      '{'{OP_STOP,  6'h15, 8'h2a}, CHECK_MODEL,  '0},
      '{'{OP_FLUSH, 6'h00, 8'h00}, CHECK_MODEL,  '0},
      '{'{OP_PUT,   6'h00, 8'h01}, CHECK_SILENT, '0},
      '{'{OP_CLEAR, 6'h3f, 8'hff}, CHECK_SILENT, '0},
      '{'{OP_FLUSH, 6'h00, 8'h00}, CHECK_SILENT, '0},  // the clear emptied the queue
      '{'{OP_STOP,  6'h00, 8'h00}, CHECK_MODEL,  '0},
      '{'{OP_PUT,   6'h15, 8'h5a}, CHECK_SILENT, '0},
      '{'{OP_PUT,   6'h2a, 8'hc3}, CHECK_SILENT, '0},
      '{'{OP_PUT,   6'h15, 8'h00}, CHECK_SILENT, '0},
      '{'{OP_FLUSH, 6'h00, 8'h00}, CHECK_MODEL,  '0},
      '{'{OP_STOP,  6'h3f, 8'h00}, CHECK_MODEL,  '0}
   };

   register_shadow_change_queue DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic void note_error(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
   endfunction

   function automatic void clear_mirror();
      foreach (shadow_mirror[i]) begin
         shadow_mirror[i] = '0;
      end
      pending_count = 0;
   endfunction

   // Applies one accepted operation to the mirror; the chip writes it causes land in
   // new_writes. Returns 0 for an operation that the block ignores.
   function automatic bit apply_to_mirror(input req_type t);
      int unsigned k;
      new_writes.delete();
      case (t.opcode)
         OP_PUT: begin
            if (shadow_mirror[t.reg_addr] == t.write_value) return 1'b0;
            shadow_mirror[t.reg_addr] = t.write_value;
            if (pending_count < QUEUE_DEPTH_DEF) begin
               pending_addr[pending_count]  = t.reg_addr;
               pending_value[pending_count] = t.write_value;
               pending_count++;
            end else begin
               puts_dropped++;
            end
            return 1'b1;
         end
         OP_FLUSH: begin
            if (!dev_present || pending_count == 0) return 1'b0;
            for (k = 0; k < pending_count; k++) begin
               new_writes.push_back('{pending_addr[k], pending_value[k], k + 1 == pending_count});
            end
            pending_count = 0;
            return 1'b1;
         end
         OP_STOP: begin
            if (!dev_present) return 1'b0;
            for (k = 32'(KEY_REG_FIRST); k <= 32'(KEY_REG_LAST); k++) begin
               new_writes.push_back('{REG_ADDR_W'(k), shadow_mirror[k] & KEY_OFF_MASK,
                                      k == 32'(KEY_REG_LAST)});
            end
            return 1'b1;
         end
         default: begin
            clear_mirror();
            return 1'b1;
         end
      endcase
   endfunction

   function automatic req_type draw_op();
      req_type     t;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 2) == 0) begin
         t.reg_addr = REG_ADDR_W'($urandom_range(32'(KEY_REG_FIRST), 32'(KEY_REG_LAST)));
      end else begin
         t.reg_addr = REG_ADDR_W'($urandom_range(0, REG_COUNT_DEF - 1));
      end
      t.write_value = VALUE_W'($urandom_range(0, 255));
      if (pick < 70) begin
         t.opcode = OP_PUT;
         if ($urandom_range(0, 4) == 0) t.write_value = shadow_mirror[t.reg_addr];
      end else if (pick < 83) begin
         t.opcode = OP_FLUSH;
      end else if (pick < 96) begin
         t.opcode = OP_STOP;
      end else begin
         t.opcode = OP_CLEAR;
      end
      return t;
   endfunction

   task automatic send_op(input req_type t);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic issue_op(input req_type t, input check_kind_type kind, input rsp_type want);
      send_op(t);
      items_sent++;
      if (apply_to_mirror(t)) ops_applied++;
      case (kind)
         CHECK_MODEL: begin
            foreach (new_writes[i]) begin
               expected_writes.push_back(new_writes[i]);
            end
         end
         CHECK_SINGLE: expected_writes.push_back(want);
         default: ;
      endcase
   endtask

   // Waits for every expected chip write, then lets a put in flight finish.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr[2] == CSR_IDX_DEVICE_PRESENT) dev_present = data[0];
   endtask

   task automatic csr_check_present();
      logic [CSR_DATA_W-1:0] want;
      want = {{(CSR_DATA_W - 1){1'b0}}, dev_present};
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= PRESENT_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== want) begin
         note_error($sformatf("device_present read %h, expected %h", csr_prdata, want));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Runs random operations until n of them had an effect on the block.
   task automatic run_random(input int unsigned n);
      int unsigned goal;
      goal = ops_applied + n;
      while (ops_applied < goal) begin
         issue_op(draw_op(), CHECK_MODEL, '0);
      end
   endtask

   // Result side: a fresh stall length for every transaction.
   initial begin : stall_gen
      int unsigned hold;
      forever begin
         hold = steady ? 0 : $urandom_range(0, 8);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : write_checker
      rsp_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         writes_checked++;
         if (expected_writes.size() == 0) begin
            note_error($sformatf("unexpected chip write reg %h value %h last %b",
                                 rsp_data.out_reg, rsp_data.out_value, rsp_data.last));
         end else begin
            want = expected_writes.pop_front();
            if (rsp_data.out_reg !== want.out_reg) begin
               note_error($sformatf("out_reg %h, expected %h", rsp_data.out_reg, want.out_reg));
            end
            if (rsp_data.out_value !== want.out_value) begin
               note_error($sformatf("out_value %h, expected %h (reg %h)",
                                    rsp_data.out_value, want.out_value, want.out_reg));
            end
            if (rsp_data.last !== want.last) begin
               note_error($sformatf("last %b, expected %b (reg %h)",
                                    rsp_data.last, want.last, want.out_reg));
            end
         end
      end
   end

   initial begin : watchdog
      #(LIMIT_NS);
      $display("register_shadow_change_queue test failed");
      $finish;
   end

   initial begin : main_seq
      req_type     t;
      int unsigned k;
      int unsigned phase;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      steady         = 1'b0;
      errors         = 0;
      items_sent     = 0;
      ops_applied    = 0;
      writes_checked = 0;
      puts_dropped   = 0;
      clear_mirror();
      dev_present = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      csr_check_present();
      foreach (dir_table[i]) begin
         issue_op(dir_table[i].item, dir_table[i].kind, dir_table[i].want);
      end

      // Without a device, flushes and stops must stay silent and keep the queue.
      settle();
      csr_write(PRESENT_ADDR, 32'hffff_fffe);
      csr_check_present();
      run_random(30);

      settle();
      csr_write(SPARE_ADDR, 32'h0000_0001);
      csr_check_present();
      csr_write(PRESENT_ADDR, 32'h0000_0001);
      csr_check_present();

      // Every put changes the shadow, so the queue overflows before the flush.
      for (k = 0; k < QUEUE_DEPTH_DEF + 16; k++) begin
         t.opcode      = OP_PUT;
         t.reg_addr    = REG_ADDR_W'($urandom_range(0, REG_COUNT_DEF - 1));
         t.write_value = shadow_mirror[t.reg_addr] ^ VALUE_W'($urandom_range(1, 255));
         issue_op(t, CHECK_MODEL, '0);
      end
      t = '{OP_FLUSH, REG_ADDR_W'($urandom_range(0, 63)), VALUE_W'($urandom_range(0, 255))};
      issue_op(t, CHECK_MODEL, '0);

      steady = 1'b1;
      run_random(30);
      steady = 1'b0;

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         steady = (phase % 3 == 2);
         run_random(10);
         phase++;
      end
      steady = 1'b0;

      req_valid <= 1'b0;
      for (k = 0; k < DRAIN_LIMIT && expected_writes.size() != 0; k++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_writes.size() != 0) begin
         note_error($sformatf("%0d expected chip writes never arrived",
                              expected_writes.size()));
      end

      $display("Sent %0d operations (%0d effective) and checked %0d chip writes; %0d puts",
               items_sent, ops_applied, writes_checked, puts_dropped);
      $display("were dropped on a full queue, with the device both present and absent.");
      if (errors == 0) begin
         $display("register_shadow_change_queue test passed");
      end else begin
         $display("%0d mismatches in total", errors);
         $display("register_shadow_change_queue test failed");
      end
      $finish;
   end

endmodule
